>>> src/ctlex_pkg.sv
// Shared types and constants for the C token lexer.
// Holds the result word layout, token kinds, lexer modes and the keyword table.
// No dependencies.
package ctlex_pkg;

	localparam int unsigned NUM_KEYWORDS = 12;

	typedef enum logic [2:0] {
		KIND_NUMBER  = 3'd0,
		KIND_KEYWORD = 3'd1,
		KIND_IDENT   = 3'd2,
		KIND_SPECIAL = 3'd3,
		KIND_END     = 3'd4
	} token_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_IDENT  = 2'd2
	} lex_mode_t;

	typedef struct packed {
		token_kind_t token_kind;
		logic [31:0] number_value;
		logic        number_saturated;
		logic [3:0]  keyword_index;
		logic [7:0]  ident_length;
		logic [63:0] ident_text;
		logic [7:0]  special_char;
		logic [31:0] line_count;
		logic        last_result;
	} result_t;

	// Keyword text, first character in the low byte, unused bytes zero.
	localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
		64'h0000_0000_0072_6f66,   // for
		64'h0000_0065_6c69_6877,   // while
		64'h0000_0000_0000_6f64,   // do
		64'h0000_0000_0074_6e69,   // int
		64'h0000_0074_616f_6c66,   // float
		64'h0000_0000_7261_6863,   // char
		64'h0000_656c_6275_6f64,   // double
		64'h0000_6369_7461_7473,   // static
		64'h0000_6863_7469_7773,   // switch
		64'h0000_0000_6573_6163,   // case
		64'h0000_0000_6469_6f76,   // void
		64'h0000_6674_6e69_7270    // printf
	};

	localparam logic [7:0] KW_LEN [NUM_KEYWORDS] = '{
		8'd3, 8'd5, 8'd2, 8'd3, 8'd5, 8'd4, 8'd6, 8'd6, 8'd6, 8'd4, 8'd4, 8'd6
	};

	// Returns {hit, index}; the first matching keyword wins.
	function automatic logic [4:0] kw_match(input logic [63:0] text, input logic [7:0] len);
		logic       hit;
		logic [3:0] idx;
		hit = 1'b0;
		idx = 4'd0;
		for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
			if (len == KW_LEN[k] && text == KW_TEXT[k]) begin
				hit = 1'b1;
				idx = 4'(k);
			end
		end
		return {hit, idx};
	endfunction

endpackage

>>> src/ctlex_core.sv
// Lexer state machine: consumes one text byte per fire and yields 0..2 results.
// Holds the token accumulators and line counter; depends on ctlex_pkg.
module ctlex_core #(
	parameter int unsigned IDENT_CHARS_KEPT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         char_byte,
	input  logic               end_of_text,
	output logic [1:0]         push_n,
	output ctlex_pkg::result_t res0,
	output ctlex_pkg::result_t res1
);
	import ctlex_pkg::*;

	localparam int unsigned TEXT_W = 8 * IDENT_CHARS_KEPT;

	lex_mode_t          mode_q, mode_d;
	logic [31:0]        acc_q, acc_d;
	logic               ovf_q, ovf_d;
	logic [TEXT_W-1:0]  chars_q, chars_d;
	logic [TEXT_W-1:0]  chars_app;
	logic [7:0]         count_q, count_d;
	logic [31:0]        line_q, line_d;

	logic               is_digit, is_alpha, is_space, is_ident;
	logic [35:0]        acc_x10;
	logic [31:0]        acc_next;
	logic               ovf_next;
	logic [4:0]         kw;
	result_t            close_res, sec_res;
	logic               close_v, sec_v;

	assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
	assign is_alpha = ((char_byte >= 8'h41) && (char_byte <= 8'h5a))
		|| ((char_byte >= 8'h61) && (char_byte <= 8'h7a));
	assign is_space = (char_byte == 8'h20) || ((char_byte >= 8'h09) && (char_byte <= 8'h0d));
	assign is_ident = is_alpha || is_digit || (char_byte == 8'h5f) || (char_byte == 8'h24);

	// acc * 10 + digit as two shifted copies
	assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, char_byte[3:0]};
	assign ovf_next = ovf_q || (acc_x10[35:32] != 4'd0);
	assign acc_next = ovf_next ? 32'hffff_ffff : acc_x10[31:0];

	// Append: only the byte slot equal to the current count is written.
	always_comb begin
		chars_app = chars_q;
		for (int i = 0; i < IDENT_CHARS_KEPT; i++) begin
			if (count_q == 8'(i)) chars_app[8*i +: 8] = char_byte;
		end
	end

	assign kw = kw_match(64'(chars_q), count_q);

	// Token that the current mode would emit on close.
	always_comb begin
		close_res = '0;
		close_v   = 1'b0;
		unique case (mode_q)
			MODE_NUMBER: begin
				close_v                    = 1'b1;
				close_res.token_kind       = KIND_NUMBER;
				close_res.number_value     = acc_q;
				close_res.number_saturated = ovf_q;
			end
			MODE_IDENT: begin
				close_v                 = 1'b1;
				close_res.token_kind    = kw[4] ? KIND_KEYWORD : KIND_IDENT;
				close_res.keyword_index = kw[4] ? kw[3:0] : 4'd0;
				close_res.ident_length  = count_q;
				close_res.ident_text    = 64'(chars_q);
			end
			default: begin
				close_v = 1'b0;
			end
		endcase
	end

	always_comb begin
		logic closing;
		closing = 1'b0;
		mode_d  = mode_q;
		acc_d   = acc_q;
		ovf_d   = ovf_q;
		chars_d = chars_q;
		count_d = count_q;
		line_d  = line_q;
		sec_res = '0;
		sec_v   = 1'b0;
		if (end_of_text) begin
			closing            = 1'b1;
			sec_v              = 1'b1;
			sec_res.token_kind = KIND_END;
			sec_res.line_count = line_q;
			mode_d  = MODE_IDLE;
			acc_d   = '0;
			ovf_d   = 1'b0;
			chars_d = '0;
			count_d = '0;
			line_d  = 32'd1;
		end else if (mode_q == MODE_NUMBER && is_digit) begin
			acc_d = acc_next;
			ovf_d = ovf_next;
		end else if (mode_q == MODE_IDENT && is_ident) begin
			chars_d = chars_app;
			count_d = (count_q == 8'hff) ? count_q : count_q + 8'd1;
		end else begin
			// Close whatever is open, then treat the byte from idle.
			closing = 1'b1;
			mode_d  = MODE_IDLE;
			acc_d   = '0;
			ovf_d   = 1'b0;
			chars_d = '0;
			count_d = '0;
			if (is_digit) begin
				mode_d = MODE_NUMBER;
				acc_d  = {28'd0, char_byte[3:0]};
			end else if (is_alpha) begin
				mode_d  = MODE_IDENT;
				chars_d = TEXT_W'(char_byte);
				count_d = 8'd1;
			end else if (char_byte == 8'h0a) begin
				if (line_q != 32'hffff_ffff) line_d = line_q + 32'd1;
			end else if (!is_space) begin
				sec_v                = 1'b1;
				sec_res.token_kind   = KIND_SPECIAL;
				sec_res.special_char = char_byte;
			end
		end

		// Compact the results into slot order and mark the final one.
		res0 = '0;
		res1 = '0;
		if (closing && close_v) begin
			res0 = close_res;
			if (sec_v) begin
				res1             = sec_res;
				res1.last_result = 1'b1;
				push_n           = 2'd2;
			end else begin
				res0.last_result = 1'b1;
				push_n           = 2'd1;
			end
		end else if (sec_v) begin
			res0             = sec_res;
			res0.last_result = 1'b1;
			push_n           = 2'd1;
		end else begin
			push_n = 2'd0;
		end
		if (!fire) push_n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			chars_q <= '0;
			count_q <= '0;
			line_q  <= 32'd1;
		end else if (fire) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			chars_q <= chars_d;
			count_q <= count_d;
			line_q  <= line_d;
		end
	end

endmodule

>>> src/ctlex_outq.sv
// Four-word result queue: takes up to two words per cycle, gives one.
// Depends on ctlex_pkg for the result word type.
module ctlex_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  ctlex_pkg::result_t res0,
	input  ctlex_pkg::result_t res1,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output ctlex_pkg::result_t out_word
);
	import ctlex_pkg::*;

	result_t     mem_q [4];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	logic        pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign out_word  = mem_q[rd_q];
	// Room for a worst-case item of two words.
	assign room      = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_q] <= res0;
		if (push_n == 2'd2) mem_q[wr_q + 2'd1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

endmodule

>>> src/c_token_lexer.sv
// C token lexer top level: input register, lexer core and result queue.
// Uses ctlex_pkg, ctlex_core and ctlex_outq.
//
// Input channel: one text byte per word on s_axis_tdata; s_axis_tlast marks
// end of text (the byte is then ignored), which closes any open token and
// emits an end summary with the line count.
// Output channel: one token per word. m_axis_tuser gives the token kind,
// m_axis_tlast marks the last token caused by one input word.
// Path: a token becomes valid on m_axis after the input word that ends it is
// accepted, passing through the input register and then the result queue.
// Throughput: one input word per cycle while each word ends at most one
// token and the receiver keeps up. A word that both closes a token and
// yields a special character or summary produces two output words; the
// queue drains one word per cycle, which then sets the rate.
// Stall: when the receiver holds m_axis_tready low the queue fills; the core
// advances only while the queue has room for two words, and the input
// register then holds one more word before s_axis_tready drops.
// Reset: the lexer returns to idle with the line counter at 1 and the
// queue empty; no tokens are pending.
module c_token_lexer #(
	parameter int unsigned IDENT_CHARS_KEPT = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] char_byte
	input  logic         s_axis_tlast,   // end_of_text
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] number_value, [32] number_saturated, [36:33] keyword_index,
	// [44:37] ident_length, [108:45] ident_text, [116:109] special_char,
	// [148:117] line_count, [151:149] zero
	output logic [151:0] m_axis_tdata,
	output logic [2:0]   m_axis_tuser,   // [2:0] token_kind
	output logic         m_axis_tlast    // last_result
);
	import ctlex_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;
	logic        room;
	logic        core_fire;
	logic [1:0]  push_n;
	result_t     res0, res1, out_word;

	assign core_fire     = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eot_s1  <= s_axis_tlast;
		end
	end

	ctlex_core #(
		.IDENT_CHARS_KEPT(IDENT_CHARS_KEPT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (core_fire),
		.char_byte  (byte_s1),
		.end_of_text(eot_s1),
		.push_n     (push_n),
		.res0       (res0),
		.res1       (res1)
	);

	ctlex_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.res0     (res0),
		.res1     (res1),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_word (out_word)
	);

	assign m_axis_tuser = out_word.token_kind;
	assign m_axis_tlast = out_word.last_result;
	assign m_axis_tdata = {3'b000, out_word.line_count, out_word.special_char,
		out_word.ident_text, out_word.ident_length, out_word.keyword_index,
		out_word.number_saturated, out_word.number_value};

	// The end summary always closes the item that caused it.
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_END) |-> m_axis_tlast)
		else $error("end summary without last mark");

	// A pair of results carries the last mark on the second word only.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (res1.last_result && !res0.last_result))
		else $error("two-word push marks last on the wrong word");

	// Number fields stay zero on every other token kind.
	a_number_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != KIND_NUMBER) |-> (m_axis_tdata[32:0] == 33'd0))
		else $error("number field set on a non-number token");

	// The core is never fired without room for its words.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room)
		else $error("result push into a full queue");

endmodule
